### hw/rtl/hdrm_pkg.sv
package hdrm_pkg;

	// Descriptor word and field widths
	localparam int WORD_W     = 64;
	localparam int BYTES_W    = WORD_W / 8;
	localparam int FIELD_W    = 9;
	localparam int REF_CNT_W  = 16;
	localparam int TIDX_W     = 8;
	localparam int RATIO_FRAC = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;

	localparam logic [FIELD_W-1:0] FIELD_MAX = 9'd511;

	// Register indexes and reset values
	localparam logic [CFG_IDX_W-1:0]  REG_MAX_DISTANCE = 1'b0;
	localparam logic [CFG_IDX_W-1:0]  REG_RATIO_Q8     = 1'b1;
	localparam logic [CFG_DATA_W-1:0] MAX_DIST_RST     = 9'd511;
	localparam logic [CFG_DATA_W-1:0] RATIO_RST        = 9'd205;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_REF   = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_SCAN,
		ST_DRAIN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [1:0]        command;
		logic [WORD_W-1:0] word;
		logic              last_word;
	} desc_item_t;

	typedef struct packed {
		logic [REF_CNT_W-1:0] reference_index;
		logic                 matched;
		logic [TIDX_W-1:0]    target_index;
		logic [FIELD_W-1:0]   best_distance;
		logic [FIELD_W-1:0]   second_distance;
	} result_item_t;

	// Control from the sequencer to the distance pipeline
	typedef struct packed {
		logic issue;      // one target issued to the memories this cycle
		logic first;      // first word of the reference: ignore old partials
		logic last_pass;  // last word: feed sums to the best/second tracker
		logic start;      // reset the tracker
	} dist_ctrl_t;

	function automatic logic [3:0] pop8(input logic [7:0] b);
		logic [3:0] c;
		c = '0;
		for (int i = 0; i < 8; i++) begin
			c = c + {3'b000, b[i]};
		end
		return c;
	endfunction

endpackage

### hw/rtl/hdrm_desc_if.sv
interface hdrm_desc_if;
	logic                   valid;
	logic                   ready;
	hdrm_pkg::desc_item_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/hdrm_result_if.sv
interface hdrm_result_if;
	logic                   valid;
	logic                   ready;
	hdrm_pkg::result_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/hamming_descriptor_ratio_matcher_unit.sv
// Brute-force Hamming matcher with ratio test.
// descriptor channel (valid/ready): command 0 clears the target table, 1 loads
// one target word, 2 streams one reference word; lowest word first, last_word
// ends a descriptor early. Command 3 is dropped.
// result channel (valid/ready): one transaction per completed reference with
// its index, nearest target, best and second distance and the match flag.
// cfg_we/cfg_index/cfg_data write max_distance (0) and ratio_q8 (1).
// A short target has the rest of its slot zeroed, one missing word at a
// time, before the next command is taken. For each reference word one
// target per cycle goes through the shared popcount/accumulate pipeline
// over the target memory read port, then the pipeline drains. After the
// final word the result is formed in the finish step. With an empty table
// a reference word skips the scan and the final word goes straight to the
// finish step.
// The result register lets the next command in while a result waits; a new
// result waits in the finish step until the receiver takes the old one.
// Reset clears counts and word positions and restores both registers; the
// memories are not cleared, entries are always written before they are read.
module hamming_descriptor_ratio_matcher_unit #(
	parameter int MAX_TARGETS = 256,
	parameter int DESC_WORDS  = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	hdrm_desc_if.sink                       descriptor,
	hdrm_result_if.source                   result,
	input  logic                            cfg_we,
	input  logic [hdrm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hdrm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import hdrm_pkg::*;

	localparam int IDX_W  = $clog2(MAX_TARGETS);
	localparam int CNT_W  = $clog2(MAX_TARGETS+1);
	localparam int POS_W  = (DESC_WORDS > 1) ? $clog2(DESC_WORDS) : 1;
	localparam int AW     = $clog2(MAX_TARGETS*DESC_WORDS);
	localparam int DIST_W = $clog2(64*DESC_WORDS+2);
	localparam int PROD_W = DIST_W + FIELD_W;
	localparam int TEXT_W = IDX_W + TIDX_W;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(DESC_WORDS-1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_TARGETS);

	state_t               state_q, state_d;
	logic [CNT_W-1:0]     count_q;
	logic [POS_W-1:0]     load_pos_q, ref_pos_q, cur_pos_q, fill_pos_q;
	logic [AW-1:0]        fill_addr_q;
	logic [IDX_W-1:0]     scan_q;
	logic [REF_CNT_W-1:0] refcnt_q;
	logic [WORD_W-1:0]    ref_word_q;
	logic                 first_q, last_q;
	logic [CFG_DATA_W-1:0] max_dist_q, ratio_q;
	logic                 out_valid_q;
	result_item_t         out_data_q;

	logic              in_take, load_ok, load_end, ref_end, scan_end, out_load;
	logic              st_we;
	logic [AW-1:0]     st_waddr, st_raddr, load_addr;
	logic [WORD_W-1:0] st_wdata, st_rdata;
	dist_ctrl_t        ctrl;
	logic              dist_busy, part_we;
	logic [IDX_W-1:0]  part_waddr, best_idx;
	logic [DIST_W-1:0] part_wdata, part_rdata, best, second;
	logic              ok;
	logic [PROD_W-1:0] best_ext, second_ext, lhs, rhs;
	logic [TEXT_W-1:0] idx_ext;

	assign in_take   = descriptor.valid & descriptor.ready;
	assign load_ok   = count_q < FULL_CNT;
	assign load_end  = descriptor.data.last_word || (load_pos_q == LAST_POS);
	assign ref_end   = descriptor.data.last_word || (ref_pos_q == LAST_POS);
	assign scan_end  = CNT_W'(scan_q) == (count_q - CNT_W'(1));
	assign load_addr = AW'(int'(count_q) * DESC_WORDS + int'(load_pos_q));
	assign st_raddr  = AW'(int'(scan_q) * DESC_WORDS + int'(cur_pos_q));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					case (descriptor.data.command)
						CMD_LOAD: begin
							if (load_ok && load_end && (load_pos_q != LAST_POS)) begin
								state_d = ST_FILL;
							end
						end
						CMD_REF: begin
							if (count_q != '0) begin
								state_d = ST_SCAN;
							end else if (ref_end) begin
								state_d = ST_FIN;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_FILL: begin
				if (fill_pos_q == LAST_POS) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!dist_busy) begin
					state_d = last_q ? ST_FIN : ST_IDLE;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || result.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		descriptor.ready = (state_q == ST_IDLE);
		st_we            = 1'b0;
		st_waddr         = load_addr;
		st_wdata         = descriptor.data.word;
		ctrl.issue       = (state_q == ST_SCAN);
		ctrl.first       = first_q;
		ctrl.last_pass   = last_q;
		ctrl.start       = in_take && (descriptor.data.command == CMD_REF);
		out_load         = (state_q == ST_FIN) && (!out_valid_q || result.ready);
		case (state_q)
			ST_IDLE: begin
				st_we = in_take && (descriptor.data.command == CMD_LOAD) && load_ok;
			end
			ST_FILL: begin
				st_we    = 1'b1;
				st_waddr = fill_addr_q;
				st_wdata = '0;
			end
			default: st_we = 1'b0;
		endcase
	end

	// State, counters and word positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			load_pos_q  <= '0;
			ref_pos_q   <= '0;
			cur_pos_q   <= '0;
			fill_pos_q  <= '0;
			fill_addr_q <= '0;
			scan_q      <= '0;
			refcnt_q    <= '0;
			first_q     <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_take) begin
				case (descriptor.data.command)
					CMD_CLEAR: begin
						count_q    <= '0;
						load_pos_q <= '0;
						ref_pos_q  <= '0;
						refcnt_q   <= '0;
					end
					CMD_LOAD: begin
						ref_pos_q <= '0;
						if (load_ok) begin
							if (load_end) begin
								count_q    <= count_q + CNT_W'(1);
								load_pos_q <= '0;
							end else begin
								load_pos_q <= load_pos_q + POS_W'(1);
							end
							fill_addr_q <= load_addr + AW'(1);
							fill_pos_q  <= load_pos_q + POS_W'(1);
						end
					end
					CMD_REF: begin
						cur_pos_q <= ref_pos_q;
						first_q   <= (ref_pos_q == '0);
						last_q    <= ref_end;
						ref_pos_q <= ref_end ? '0 : ref_pos_q + POS_W'(1);
						scan_q    <= '0;
					end
					default: ;
				endcase
			end
			if (state_q == ST_FILL) begin
				fill_addr_q <= fill_addr_q + AW'(1);
				fill_pos_q  <= fill_pos_q + POS_W'(1);
			end
			if (state_q == ST_SCAN) begin
				scan_q <= scan_q + IDX_W'(1);
			end
			if (out_load) begin
				refcnt_q <= refcnt_q + REF_CNT_W'(1);
			end
		end
	end

	// Hold the reference word for the whole pass
	always_ff @(posedge clk) begin
		if (in_take && (descriptor.data.command == CMD_REF)) begin
			ref_word_q <= descriptor.data.word;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dist_q <= MAX_DIST_RST;
			ratio_q    <= RATIO_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_MAX_DISTANCE) begin
				max_dist_q <= cfg_data;
			end
			if (cfg_index == REG_RATIO_Q8) begin
				ratio_q <= cfg_data;
			end
		end
	end

	hdrm_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_TARGETS*DESC_WORDS)
	) u_target_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	hdrm_ram #(
		.WIDTH (DIST_W),
		.DEPTH (MAX_TARGETS)
	) u_partial_ram (
		.clk   (clk),
		.we    (part_we),
		.waddr (part_waddr),
		.wdata (part_wdata),
		.raddr (scan_q),
		.rdata (part_rdata)
	);

	hdrm_dist_unit #(
		.MAX_TARGETS (MAX_TARGETS),
		.DESC_WORDS  (DESC_WORDS)
	) u_dist (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.issue_idx     (scan_q),
		.ref_word      (ref_word_q),
		.target_word   (st_rdata),
		.partial_rd    (part_rdata),
		.partial_we    (part_we),
		.partial_waddr (part_waddr),
		.partial_wdata (part_wdata),
		.busy          (dist_busy),
		.best          (best),
		.second        (second),
		.best_idx      (best_idx)
	);

	// Distance and ratio tests, saturate distances to the field width
	assign best_ext   = PROD_W'(best);
	assign second_ext = PROD_W'(second);
	assign lhs        = best_ext << RATIO_FRAC;
	assign rhs        = PROD_W'(ratio_q) * second_ext;
	assign ok         = (count_q != '0) && (best_ext < PROD_W'(max_dist_q)) && (lhs < rhs);
	assign idx_ext    = TEXT_W'(best_idx);

	// Output register: load when free or being drained, drop on handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q.reference_index <= refcnt_q;
			out_data_q.matched         <= ok;
			out_data_q.target_index    <= idx_ext[TIDX_W-1:0];
			out_data_q.best_distance   <= (best_ext > PROD_W'(FIELD_MAX)) ?
				FIELD_MAX : best_ext[FIELD_W-1:0];
			out_data_q.second_distance <= (second_ext > PROD_W'(FIELD_MAX)) ?
				FIELD_MAX : second_ext[FIELD_W-1:0];
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	a_scan_has_targets: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (count_q != '0))
		else $error("scan started with an empty target table");

	a_no_load_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		st_we |-> ((state_q == ST_IDLE) || (state_q == ST_FILL)))
		else $error("target memory written during a reference pass");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("target count beyond table size");

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !dist_busy)
		else $error("new command taken while distance pipeline busy");

	a_fin_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> ($past(state_q) == ST_FIN || $past(state_q) == ST_DRAIN ||
			$past(state_q) == ST_IDLE))
		else $error("result formed outside the finish step");

endmodule

### hw/rtl/hdrm_ram.sv
module hdrm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/hdrm_dist_unit.sv
module hdrm_dist_unit #(
	parameter int MAX_TARGETS = 256,
	parameter int DESC_WORDS  = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  hdrm_pkg::dist_ctrl_t                  ctrl,
	input  logic [$clog2(MAX_TARGETS)-1:0]        issue_idx,
	input  logic [hdrm_pkg::WORD_W-1:0]           ref_word,
	input  logic [hdrm_pkg::WORD_W-1:0]           target_word,
	input  logic [$clog2(64*DESC_WORDS+2)-1:0]    partial_rd,
	output logic                                  partial_we,
	output logic [$clog2(MAX_TARGETS)-1:0]        partial_waddr,
	output logic [$clog2(64*DESC_WORDS+2)-1:0]    partial_wdata,
	output logic                                  busy,
	output logic [$clog2(64*DESC_WORDS+2)-1:0]    best,
	output logic [$clog2(64*DESC_WORDS+2)-1:0]    second,
	output logic [$clog2(MAX_TARGETS)-1:0]        best_idx
);
	import hdrm_pkg::*;

	localparam int IDX_W  = $clog2(MAX_TARGETS);
	localparam int DIST_W = $clog2(64*DESC_WORDS+2);
	localparam logic [DIST_W-1:0] NONE_DIST = DIST_W'(64*DESC_WORDS+1);

	logic              v_s1, v_s2, v_s3;
	logic [IDX_W-1:0]  idx_s1, idx_s2, idx_s3;
	logic [3:0]        bc_s2 [BYTES_W];
	logic [DIST_W-1:0] part_s2;
	logic [DIST_W-1:0] sum_s3;
	logic [DIST_W-1:0] acc;
	logic [WORD_W-1:0] diff;
	logic [DIST_W-1:0] best_q, second_q;
	logic [IDX_W-1:0]  best_idx_q;

	// Track valid entries through the three stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= ctrl.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: byte counts of the XOR, take partial sum from memory
	assign diff = ref_word ^ target_word;

	always_ff @(posedge clk) begin
		idx_s1 <= issue_idx;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		for (int i = 0; i < BYTES_W; i++) begin
			bc_s2[i] <= pop8(diff[8*i +: 8]);
		end
		part_s2 <= ctrl.first ? '0 : partial_rd;
		sum_s3  <= acc;
	end

	// Stage 2: add byte counts onto the partial distance and write back
	always_comb begin
		acc = part_s2;
		for (int i = 0; i < BYTES_W; i++) begin
			acc = acc + DIST_W'(bc_s2[i]);
		end
	end

	assign partial_we    = v_s2;
	assign partial_waddr = idx_s2;
	assign partial_wdata = acc;

	// Stage 3: keep nearest and second nearest; lower index wins ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q     <= NONE_DIST;
			second_q   <= NONE_DIST;
			best_idx_q <= '0;
		end else if (ctrl.start) begin
			best_q     <= NONE_DIST;
			second_q   <= NONE_DIST;
			best_idx_q <= '0;
		end else if (v_s3 && ctrl.last_pass) begin
			if (sum_s3 < best_q) begin
				second_q   <= best_q;
				best_q     <= sum_s3;
				best_idx_q <= idx_s3;
			end else if (sum_s3 < second_q) begin
				second_q <= sum_s3;
			end
		end
	end

	assign busy     = v_s1 | v_s2 | v_s3;
	assign best     = best_q;
	assign second   = second_q;
	assign best_idx = best_idx_q;

endmodule
